// ----- hw/rtl/shadow_slot_allocator_assert.svh -----
// Assertion macros used by the slot allocator datapath
`ifndef SHADOW_SLOT_ALLOCATOR_ASSERT_SVH
`define SHADOW_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SSA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ssa_pkg.sv -----
// Types, codes and helpers shared by the slot allocator modules
`timescale 1ns / 1ps

package ssa_pkg;

	localparam int HANDLE_W   = 7;
	localparam int OWNER_W    = 16;
	localparam int SIZE_W     = 16;
	localparam int UNIT_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INV   = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SHARED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd2;

	localparam logic              RST_SHARED = 1'b1;
	localparam logic [UNIT_W-1:0] RST_LIMIT  = 8'd32;
	localparam logic [UNIT_W-1:0] RST_FIRST  = 8'd0;

	// Owner memory read address source
	typedef enum logic [1:0] {
		OWN_FS  = 2'd0,
		OWN_CNT = 2'd1,
		OWN_IDX = 2'd2
	} own_sel_t;

	typedef struct packed {
		logic     start;
		logic     fs_cnt;
		own_sel_t own_sel;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     srch_issue;
		logic     inv_issue;
		logic     load_top;
		logic     grow;
		logic     swap;
		logic     alloc_fin;
		logic     free_fin;
		logic     set_err;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic depth_zero;
		logic grow_ok;
		logic free_ok;
		logic slot_used;
		logic need_search;
		logic srch_last;
		logic inv_last;
		logic inv_skip;
	} stat_t;

	// Unit number of a slot before wrapping to UNIT_W bits
	function automatic logic [UNIT_W:0] unit_sum(input logic [UNIT_W-1:0] first,
			input logic shared, input logic [UNIT_W-1:0] idx);
		logic [UNIT_W:0] off;
		off = shared ? '0 : {1'b0, idx};
		return {1'b0, first} + off;
	endfunction

endpackage

// ----- hw/rtl/ssa_datapath.sv -----
// Slot allocator datapath: config, counters, slot memories, search and scan pipes
`timescale 1ns / 1ps
`include "shadow_slot_allocator_assert.svh"

module ssa_datapath #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                          opcode,
	input  logic [ssa_pkg::OWNER_W-1:0]         owner_id,
	input  logic [ssa_pkg::HANDLE_W-1:0]        handle,
	input  logic [ssa_pkg::SIZE_W-1:0]          map_size,
	input  ssa_pkg::cmd_t                       cmd,
	output ssa_pkg::stat_t                      stat,
	output logic [ssa_pkg::HANDLE_W-1:0]        result_handle,
	output logic                                id_matched,
	output logic                                size_changed,
	output logic [ssa_pkg::UNIT_W-1:0]          texture_unit,
	output logic                                error
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int XW = (CW > ssa_pkg::HANDLE_W) ? CW : ssa_pkg::HANDLE_W;
	localparam logic [XW-1:0] SLOTS_X = XW'(SLOT_COUNT);

	// configuration
	logic                        shared_q;
	logic [ssa_pkg::UNIT_W-1:0]  limit_q;
	logic [ssa_pkg::UNIT_W-1:0]  first_q;

	// latched item
	logic [1:0]                  op_q;
	logic [ssa_pkg::OWNER_W-1:0] owner_q;
	logic [ssa_pkg::HANDLE_W-1:0] handle_q;
	logic [ssa_pkg::SIZE_W-1:0]  size_q;

	logic [CW-1:0] grown_q;
	logic [CW-1:0] depth_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] top_slot_q;
	logic [IW-1:0] hit_slot_q;
	logic [IW-1:0] hit_pos_q;
	logic          found_q;

	logic          srch_v_s1;
	logic          srch_v_s2;
	logic [IW-1:0] pos_s1;
	logic [IW-1:0] pos_s2;
	logic [IW-1:0] slot_s2;
	logic          inv_v_s1;
	logic [IW-1:0] inv_pos_s1;

	// memories and registered read data
	logic [IW-1:0]               fs_mem   [SLOT_COUNT];
	logic [ssa_pkg::OWNER_W-1:0] own_mem  [SLOT_COUNT];
	logic [ssa_pkg::SIZE_W-1:0]  size_mem [SLOT_COUNT];
	logic                        use_mem  [SLOT_COUNT];
	logic [IW-1:0]               fs_rd_q;
	logic [ssa_pkg::OWNER_W-1:0] own_rd_q;
	logic [ssa_pkg::SIZE_W-1:0]  size_rd_q;
	logic                        use_rd_q;

	// result staging and output registers
	logic [ssa_pkg::HANDLE_W-1:0] res_handle_q;
	logic                         res_match_q;
	logic                         res_size_q;
	logic [ssa_pkg::UNIT_W-1:0]   res_unit_q;
	logic                         res_err_q;
	logic [ssa_pkg::HANDLE_W-1:0] out_handle_q;
	logic                         out_match_q;
	logic                         out_size_q;
	logic [ssa_pkg::UNIT_W-1:0]   out_unit_q;
	logic                         out_err_q;

	logic [CW-1:0]                depth_m1;
	logic [CW-1:0]                grown_m1;
	logic [ssa_pkg::HANDLE_W-1:0] handle_m1;
	logic [IW-1:0]                top_idx;
	logic [IW-1:0]                grown_idx;
	logic [IW-1:0]                depth_idx;
	logic [IW-1:0]                hidx;
	logic [IW-1:0]                idx_sel;
	logic [XW-1:0]                grown_x;
	logic [XW-1:0]                depth_x;
	logic [XW-1:0]                handle_x;
	logic [ssa_pkg::UNIT_W:0]     grow_unit;
	logic [ssa_pkg::UNIT_W:0]     idx_unit;
	logic [7:0]                   grow_h;
	logic [7:0]                   idx_h;
	logic                         hit;
	logic                         inv_hit;
	logic                         size_chg;

	logic [IW-1:0] fs_raddr;
	logic [IW-1:0] own_raddr;
	logic          fs_we;
	logic [IW-1:0] fs_waddr;
	logic [IW-1:0] fs_wdata;
	logic          own_we;
	logic [IW-1:0] own_waddr;
	logic [ssa_pkg::OWNER_W-1:0] own_wdata;
	logic          size_we;
	logic [IW-1:0] size_waddr;
	logic          use_we;
	logic [IW-1:0] use_waddr;
	logic          use_wdata;

	assign depth_m1  = depth_q - CW'(1);
	assign grown_m1  = grown_q - CW'(1);
	assign handle_m1 = handle_q - ssa_pkg::HANDLE_W'(1);
	assign top_idx   = depth_m1[IW-1:0];
	assign grown_idx = grown_q[IW-1:0];
	assign depth_idx = depth_q[IW-1:0];
	assign hidx      = handle_m1[IW-1:0];
	assign idx_sel   = found_q ? hit_slot_q : top_slot_q;
	assign grown_x   = XW'(grown_q);
	assign depth_x   = XW'(depth_q);
	assign handle_x  = XW'(handle_q);

	assign grow_unit = ssa_pkg::unit_sum(first_q, shared_q, ssa_pkg::UNIT_W'(grown_idx));
	assign idx_unit  = ssa_pkg::unit_sum(first_q, shared_q, ssa_pkg::UNIT_W'(idx_sel));
	assign grow_h    = 8'(grown_idx) + 8'd1;
	assign idx_h     = 8'(idx_sel) + 8'd1;

	assign hit      = srch_v_s2 && (own_rd_q == owner_q) && !found_q;
	assign inv_hit  = inv_v_s1 && (own_rd_q == owner_q);
	assign size_chg = (size_q != '0) && (size_rd_q != size_q);

	always_comb begin
		stat.op          = ssa_pkg::op_t'(op_q);
		stat.depth_zero  = (depth_q == '0);
		stat.grow_ok     = (grown_x < SLOTS_X) && (grow_unit < {1'b0, limit_q});
		stat.free_ok     = (handle_q != '0) && (handle_x <= grown_x) &&
			(handle_x <= SLOTS_X) && (depth_x < SLOTS_X);
		stat.slot_used   = use_rd_q;
		stat.need_search = (owner_q != '0) || (own_rd_q != '0);
		stat.srch_last   = (cnt_q == top_idx);
		stat.inv_last    = (cnt_q == grown_m1[IW-1:0]);
		stat.inv_skip    = (owner_q == '0) || (grown_q == '0);
	end

	// read address selection
	always_comb begin
		fs_raddr = cmd.fs_cnt ? cnt_q : top_idx;
		case (cmd.own_sel)
			ssa_pkg::OWN_FS:  own_raddr = fs_rd_q;
			ssa_pkg::OWN_CNT: own_raddr = cnt_q;
			ssa_pkg::OWN_IDX: own_raddr = idx_sel;
			default:          own_raddr = idx_sel;
		endcase
	end

	// write port selection
	always_comb begin
		fs_we     = cmd.free_fin || (cmd.swap && found_q);
		fs_waddr  = cmd.free_fin ? depth_idx : hit_pos_q;
		fs_wdata  = cmd.free_fin ? hidx : top_slot_q;

		own_we    = cmd.grow || cmd.alloc_fin || inv_hit;
		own_waddr = inv_pos_s1;
		own_wdata = '0;
		if (cmd.grow) begin
			own_waddr = grown_idx;
			own_wdata = owner_q;
		end else if (cmd.alloc_fin) begin
			own_waddr = idx_sel;
			own_wdata = owner_q;
		end

		size_we    = cmd.grow || (cmd.alloc_fin && size_chg);
		size_waddr = cmd.grow ? grown_idx : idx_sel;

		use_we    = cmd.grow || cmd.alloc_fin || cmd.free_fin;
		use_waddr = idx_sel;
		use_wdata = 1'b1;
		if (cmd.grow) begin
			use_waddr = grown_idx;
		end else if (cmd.free_fin) begin
			use_waddr = hidx;
			use_wdata = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		fs_rd_q <= fs_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[own_waddr] <= own_wdata;
		end
		own_rd_q <= own_mem[own_raddr];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_q;
		end
		size_rd_q <= size_mem[idx_sel];
	end

	always_ff @(posedge clk) begin
		if (use_we) begin
			use_mem[use_waddr] <= use_wdata;
		end
		use_rd_q <= use_mem[hidx];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q  <= ssa_pkg::RST_SHARED;
			limit_q   <= ssa_pkg::RST_LIMIT;
			first_q   <= ssa_pkg::RST_FIRST;
			grown_q   <= '0;
			depth_q   <= '0;
			found_q   <= 1'b0;
			srch_v_s1 <= 1'b0;
			srch_v_s2 <= 1'b0;
			inv_v_s1  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ssa_pkg::CFG_SHARED: shared_q <= cfg_data[0];
					ssa_pkg::CFG_LIMIT:  limit_q  <= cfg_data;
					ssa_pkg::CFG_FIRST:  first_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.grow) begin
				grown_q <= grown_q + CW'(1);
			end
			if (cmd.alloc_fin) begin
				depth_q <= depth_m1;
			end else if (cmd.free_fin) begin
				depth_q <= depth_q + CW'(1);
			end
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			srch_v_s1 <= cmd.srch_issue;
			srch_v_s2 <= srch_v_s1;
			inv_v_s1  <= cmd.inv_issue;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q         <= opcode;
			owner_q      <= owner_id;
			handle_q     <= handle;
			size_q       <= map_size;
			res_handle_q <= '0;
			res_match_q  <= 1'b0;
			res_size_q   <= 1'b0;
			res_unit_q   <= '0;
			res_err_q    <= 1'b0;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + IW'(1);
		end
		if (cmd.load_top) begin
			top_slot_q <= fs_rd_q;
		end
		pos_s1     <= cnt_q;
		pos_s2     <= pos_s1;
		slot_s2    <= fs_rd_q;
		inv_pos_s1 <= cnt_q;
		if (hit) begin
			hit_slot_q <= slot_s2;
			hit_pos_q  <= pos_s2;
		end
		if (cmd.grow) begin
			res_handle_q <= grow_h[ssa_pkg::HANDLE_W-1:0];
			res_size_q   <= (size_q != '0);
			res_unit_q   <= grow_unit[ssa_pkg::UNIT_W-1:0];
		end
		if (cmd.alloc_fin) begin
			res_handle_q <= idx_h[ssa_pkg::HANDLE_W-1:0];
			res_match_q  <= (owner_q != '0) && (own_rd_q == owner_q);
			res_size_q   <= size_chg;
			res_unit_q   <= idx_unit[ssa_pkg::UNIT_W-1:0];
		end
		if (cmd.set_err) begin
			res_err_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_handle_q <= res_handle_q;
			out_match_q  <= res_match_q;
			out_size_q   <= res_size_q;
			out_unit_q   <= res_unit_q;
			out_err_q    <= res_err_q;
		end
	end

	assign result_handle = out_handle_q;
	assign id_matched    = out_match_q;
	assign size_changed  = out_size_q;
	assign texture_unit  = out_unit_q;
	assign error         = out_err_q;

	`SSA_ASSERT_IMPL(a_depth_le_grown, 1'b1, depth_q <= grown_q, "free list deeper than grown slots")
	`SSA_ASSERT_IMPL(a_grown_le_slots, 1'b1, grown_x <= SLOTS_X, "grown count above slot limit")
	`SSA_ASSERT_IMPL(a_found_from_s2, $rose(found_q), $past(srch_v_s2), "search hit without stage 2")
	`SSA_ASSERT_IMPL(a_pop_nonempty, cmd.alloc_fin, depth_q != '0, "pop from empty free list")
	`SSA_ASSERT_NEXT(a_pop_depth, cmd.alloc_fin, depth_q == $past(depth_m1), "pop did not drop depth")

endmodule

// ----- hw/rtl/ssa_ctrl.sv -----
// Slot allocator controller: sequences each item and owns the handshakes
`timescale 1ns / 1ps

module ssa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ssa_pkg::stat_t stat,
	output ssa_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_A_TOP,
		S_A_TOPO,
		S_A_TOPC,
		S_SRCH,
		S_SDR1,
		S_SDR2,
		S_A_FRD,
		S_A_FIN,
		S_F_RD,
		S_F_CHK,
		S_INV,
		S_IDR,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.own_sel = ssa_pkg::OWN_IDX;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_OUT;
				unique case (stat.op)
					ssa_pkg::OP_ALLOC: begin
						if (!stat.depth_zero) begin
							state_d = S_A_TOP;
						end else if (stat.grow_ok) begin
							cmd.grow = 1'b1;
						end
					end
					ssa_pkg::OP_FREE: begin
						if (stat.free_ok) begin
							state_d = S_F_RD;
						end else begin
							cmd.set_err = 1'b1;
						end
					end
					ssa_pkg::OP_INV: begin
						if (!stat.inv_skip) begin
							cmd.cnt_clr = 1'b1;
							state_d     = S_INV;
						end
					end
					default: ;
				endcase
			end
			S_A_TOP: begin
				state_d = S_A_TOPO;
			end
			S_A_TOPO: begin
				cmd.own_sel  = ssa_pkg::OWN_FS;
				cmd.load_top = 1'b1;
				state_d      = S_A_TOPC;
			end
			S_A_TOPC: begin
				if (stat.need_search) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_SRCH;
				end else begin
					state_d = S_A_FRD;
				end
			end
			S_SRCH: begin
				cmd.fs_cnt     = 1'b1;
				cmd.own_sel    = ssa_pkg::OWN_FS;
				cmd.srch_issue = 1'b1;
				cmd.cnt_inc    = 1'b1;
				if (stat.srch_last) begin
					state_d = S_SDR1;
				end
			end
			S_SDR1: begin
				cmd.own_sel = ssa_pkg::OWN_FS;
				state_d     = S_SDR2;
			end
			S_SDR2: begin
				state_d = S_A_FRD;
			end
			S_A_FRD: begin
				cmd.swap = 1'b1;
				state_d  = S_A_FIN;
			end
			S_A_FIN: begin
				cmd.alloc_fin = 1'b1;
				state_d       = S_OUT;
			end
			S_F_RD: begin
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (stat.slot_used) begin
					cmd.free_fin = 1'b1;
				end else begin
					cmd.set_err = 1'b1;
				end
				state_d = S_OUT;
			end
			S_INV: begin
				cmd.own_sel   = ssa_pkg::OWN_CNT;
				cmd.inv_issue = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (stat.inv_last) begin
					state_d = S_IDR;
				end
			end
			S_IDR: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the previous result has been taken
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/shadow_slot_allocator.sv -----
// Top level of the tagged LIFO slot allocator
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    opcode, owner_id, handle, map_size
//   out      source     out_valid / out_ready  result_handle, id_matched, size_changed,
//                                              texture_unit, error
//   cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// One item at a time; grow, nop, refused items and a skipped invalidate go straight to
// the output state, an in-range free first reads the slot's use bit, a pop reads the
// free-list top and may search it by owner, and invalidate scans each grown slot in turn.
// Search and scan are serial through one read port on the free-list and owner memories.
// Reset clears counters and control; slot memories need no clearing pass.
// A waiting result is held in the output register while the next item is accepted.
`timescale 1ns / 1ps

module shadow_slot_allocator #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic [ssa_pkg::OWNER_W-1:0]    owner_id,
	input  logic [ssa_pkg::HANDLE_W-1:0]   handle,
	input  logic [ssa_pkg::SIZE_W-1:0]     map_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ssa_pkg::HANDLE_W-1:0]   result_handle,
	output logic                           id_matched,
	output logic                           size_changed,
	output logic [ssa_pkg::UNIT_W-1:0]     texture_unit,
	output logic                           error
);

	ssa_pkg::cmd_t  cmd;
	ssa_pkg::stat_t stat;

	ssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.owner_id      (owner_id),
		.handle        (handle),
		.map_size      (map_size),
		.cmd           (cmd),
		.stat          (stat),
		.result_handle (result_handle),
		.id_matched    (id_matched),
		.size_changed  (size_changed),
		.texture_unit  (texture_unit),
		.error         (error)
	);

endmodule
